>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
//
// Clocked concurrent assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define SACM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every rising clock edge, reset included.
`define SACM_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/sacm_pkg.sv
// ----------------------------------------------------------------------------
// sacm_pkg
//
// Shared types, constants and the victim LFSR step of the cache hit model.
// ----------------------------------------------------------------------------
package sacm_pkg;

   localparam int ADDR_W     = 32;
   localparam int CNT_W      = 32;
   localparam int LFSR_W     = 16;
   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_STORE = 1'b1;

   typedef struct packed {
      logic clear;        // clear one row of valid bits
      logic accept;       // capture request, read set rows
      logic pick_victim;  // advance LFSR, latch victim way
      logic commit;       // update store, counters, output register
   } cmd_type;

   typedef struct packed {
      logic load_miss;
      logic clear_last;
   } status_type;

   // Fibonacci, taps 16,14,13,11, shifting right
   function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
      logic fb;
      fb = s[0] ^ s[2] ^ s[3] ^ s[5];
      return {fb, s[LFSR_W-1:1]};
   endfunction

endpackage

>>> rtl/sacm_ctrl.sv
// ----------------------------------------------------------------------------
// sacm_ctrl
//
// Controller state machine: clearing pass, request, lookup with victim pick
// and result commit.
// ----------------------------------------------------------------------------
module sacm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sacm_pkg::cmd_type      cmd,
   input  sacm_pkg::status_type   status
);
   import sacm_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_LOOKUP = 4'b0100,
      ST_RESULT = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (status.load_miss) cmd.pick_victim = 1'b1;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   assign rsp_valid_in = cmd.commit ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/sacm_datapath.sv
// ----------------------------------------------------------------------------
// sacm_datapath
//
// Tag and valid memories, way compare, victim LFSR with modulo by reciprocal,
// hit and miss counters and the result register.
// ----------------------------------------------------------------------------
module sacm_datapath #(
   parameter int OFF_BITS = 6,
   parameter int SET_BITS = 3,
   parameter int WAYS     = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sacm_pkg::cmd_type             cmd,
   output sacm_pkg::status_type          status,
   input  logic                          req_op,
   input  logic [sacm_pkg::ADDR_W-1:0]   req_address,
   output logic                          rsp_hit,
   output logic                          rsp_way,
   output logic                          rsp_filled,
   output logic [sacm_pkg::CNT_W-1:0]    rsp_hit_total,
   output logic [sacm_pkg::CNT_W-1:0]    rsp_miss_total
);
   import sacm_pkg::*;

   localparam int NUM_SETS  = 1 << SET_BITS;
   localparam int SET_IDX_W = (SET_BITS == 0) ? 1 : SET_BITS;
   localparam int SHIFT     = OFF_BITS + SET_BITS;
   localparam int TAG_W     = ADDR_W - SHIFT;
   localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam logic [SET_IDX_W-1:0] SET_MASK = SET_IDX_W'(NUM_SETS - 1);
   localparam logic [SET_IDX_W-1:0] SET_LAST = SET_IDX_W'(NUM_SETS - 1);

   // exact floor(x / WAYS) for any LFSR value: x * RCP_M >> RCP_SH
   localparam int RCP_SH = LFSR_W + $clog2(WAYS);
   localparam int RCP_W  = LFSR_W + 1;
   localparam int PRD_W  = LFSR_W + RCP_W;
   localparam logic [RCP_W-1:0] RCP_M =
      RCP_W'(((64'd1 << RCP_SH) + 64'(WAYS) - 64'd1) / 64'(WAYS));

   // memories: one row per set
   logic [WAYS*TAG_W-1:0] tag_mem   [NUM_SETS];
   logic [WAYS-1:0]       valid_mem [NUM_SETS];

   logic [WAYS*TAG_W-1:0] tag_row_ff;
   logic [WAYS-1:0]       valid_row_ff;
   logic                  op_ff;
   logic [ADDR_W-1:0]     addr_ff;

   logic [SET_IDX_W-1:0]  req_set, cur_set;
   logic [TAG_W-1:0]      cur_tag;

   logic [SET_IDX_W-1:0]  clr_ptr_ff, clr_ptr_in;
   logic                  clear_last;

   logic [LFSR_W-1:0]     lfsr_ff, lfsr_in, lfsr_nx;
   logic [PRD_W-1:0]      rcp_prod;
   logic [LFSR_W-1:0]     rcp_quo;
   logic [LFSR_W-1:0]     rcp_rem;
   logic [WAY_W-1:0]      victim_way;
   logic [WAY_W-1:0]      res_ff, res_in;

   logic                  hit;
   logic [WAY_W-1:0]      hit_way;
   logic                  is_load, fill;

   logic [WAYS*TAG_W-1:0] tag_row_wr;
   logic [WAYS-1:0]       valid_row_wr;
   logic                  valid_we;
   logic [SET_IDX_W-1:0]  valid_addr;
   logic [WAYS-1:0]       valid_data;

   logic [CNT_W-1:0]      hit_cnt_ff, hit_cnt_in;
   logic [CNT_W-1:0]      miss_cnt_ff, miss_cnt_in;
   logic                  rsp_hit_ff, rsp_way_ff, rsp_filled_ff;
   logic [CNT_W-1:0]      rsp_hit_total_ff, rsp_miss_total_ff;

   // address split
   assign req_set = SET_IDX_W'(req_address >> OFF_BITS) & SET_MASK;
   assign cur_set = SET_IDX_W'(addr_ff >> OFF_BITS) & SET_MASK;
   assign cur_tag = TAG_W'(addr_ff >> SHIFT);

   // way compare; the highest matching way wins
   always_comb begin
      hit     = 1'b0;
      hit_way = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (valid_row_ff[i] && (tag_row_ff[i*TAG_W +: TAG_W] == cur_tag)) begin
            hit     = 1'b1;
            hit_way = WAY_W'(i);
         end
      end
   end

   assign is_load = (op_ff == OP_LOAD);
   assign fill    = is_load && !hit;

   // victim way: the new LFSR value modulo WAYS
   assign lfsr_nx    = lfsr_step(lfsr_ff);
   assign rcp_prod   = PRD_W'(lfsr_nx) * PRD_W'(RCP_M);
   assign rcp_quo    = LFSR_W'(rcp_prod >> RCP_SH);
   assign rcp_rem    = lfsr_nx - (rcp_quo * LFSR_W'(WAYS));
   assign victim_way = WAY_W'(rcp_rem);

   always_comb begin
      lfsr_in = lfsr_ff;
      res_in  = res_ff;
      if (cmd.pick_victim) begin
         lfsr_in = lfsr_nx;
         res_in  = victim_way;
      end
   end

   // row images for the fill
   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         tag_row_wr[i*TAG_W +: TAG_W] = (WAY_W'(i) == res_ff) ? cur_tag :
                                        tag_row_ff[i*TAG_W +: TAG_W];
         valid_row_wr[i] = (WAY_W'(i) == res_ff) ? 1'b1 : valid_row_ff[i];
      end
   end

   // clearing pass over the valid memory
   assign clear_last = (clr_ptr_ff == SET_LAST);
   assign clr_ptr_in = cmd.clear ? (clear_last ? '0 : clr_ptr_ff + 1'b1) : clr_ptr_ff;

   assign valid_we   = cmd.clear || (cmd.commit && fill);
   assign valid_addr = cmd.clear ? clr_ptr_ff : cur_set;
   assign valid_data = cmd.clear ? '0 : valid_row_wr;

   always_ff @(posedge clock) begin
      if (cmd.commit && fill) tag_mem[cur_set] <= tag_row_wr;
      if (cmd.accept) tag_row_ff <= tag_mem[req_set];
   end

   always_ff @(posedge clock) begin
      if (valid_we) valid_mem[valid_addr] <= valid_data;
      if (cmd.accept) valid_row_ff <= valid_mem[req_set];
   end

   // counters
   assign hit_cnt_in  = hit_cnt_ff  + CNT_W'(is_load && hit);
   assign miss_cnt_in = miss_cnt_ff + CNT_W'(fill);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff  <= '0;
         lfsr_ff     <= LFSR_SEED;
         hit_cnt_ff  <= '0;
         miss_cnt_ff <= '0;
      end else begin
         clr_ptr_ff <= clr_ptr_in;
         lfsr_ff    <= lfsr_in;
         if (cmd.commit) begin
            hit_cnt_ff  <= hit_cnt_in;
            miss_cnt_ff <= miss_cnt_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (cmd.accept) begin
         op_ff   <= req_op;
         addr_ff <= req_address;
      end
      if (cmd.commit) begin
         rsp_hit_ff        <= hit;
         rsp_way_ff        <= fill ? res_ff[0] : hit_way[0];
         rsp_filled_ff     <= fill;
         rsp_hit_total_ff  <= hit_cnt_in;
         rsp_miss_total_ff <= miss_cnt_in;
      end
   end

   assign status.load_miss  = fill;
   assign status.clear_last = clear_last;

   assign rsp_hit        = rsp_hit_ff;
   assign rsp_way        = rsp_way_ff;
   assign rsp_filled     = rsp_filled_ff;
   assign rsp_hit_total  = rsp_hit_total_ff;
   assign rsp_miss_total = rsp_miss_total_ff;

endmodule

>>> rtl/set_assoc_cache_hit_model.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_hit_model
//
// Tag-only set-associative cache model with pseudo-random replacement. Each
// request transfer carries one access (load or store) and yields one response
// transfer with hit, way, filled and the running load hit and miss totals.
// Requests are taken one at a time and every access passes through accept,
// lookup on the registered tag and valid rows, and commit. On a load miss the
// lookup cycle also advances the LFSR and latches the victim way, the new
// LFSR value modulo WAYS, found by a reciprocal multiplication. The next
// request is accepted while the previous response still waits in the output
// register; commit waits only while that register is occupied and stalled.
// After reset the valid memory is cleared one set per cycle, all 2**SET_BITS
// sets (8 at the default geometry), with req_stall high. Stores are
// no-allocate and never move the counters; both counters wrap at 32 bits.
// ----------------------------------------------------------------------------
module set_assoc_cache_hit_model #(
   parameter int CACHE_BYTES = 1024,
   parameter int BLOCK_WORDS = 16,
   parameter int WAYS        = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic [sacm_pkg::ADDR_W-1:0]   req_address,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic                          rsp_way,
   output logic                          rsp_filled,
   output logic [sacm_pkg::CNT_W-1:0]    rsp_hit_total,
   output logic [sacm_pkg::CNT_W-1:0]    rsp_miss_total
);
   import sacm_pkg::*;

   // Geometry: sizes round down to powers of two; fewer blocks than ways
   // collapses to a single set.
   localparam int BLOCK_BYTES = BLOCK_WORDS * 4;
   localparam int BLOCKS      = CACHE_BYTES / BLOCK_BYTES;
   localparam int SETS_RAW    = BLOCKS / WAYS;
   localparam int SETS        = (SETS_RAW == 0) ? 1 : SETS_RAW;
   localparam int OFF_BITS    = $clog2(BLOCK_BYTES + 1) - 1;
   localparam int SET_BITS    = $clog2(SETS + 1) - 1;

   cmd_type    cmd;
   status_type status;

   // Controller: sequences each request and owns both handshakes.
   sacm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Datapath: memories, compare, victim choice, counters, result register.
   sacm_datapath #(
      .OFF_BITS (OFF_BITS),
      .SET_BITS (SET_BITS),
      .WAYS     (WAYS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_op         (req_op),
      .req_address    (req_address),
      .rsp_hit        (rsp_hit),
      .rsp_way        (rsp_way),
      .rsp_filled     (rsp_filled),
      .rsp_hit_total  (rsp_hit_total),
      .rsp_miss_total (rsp_miss_total)
   );

endmodule

>>> rtl/sacm_checker.sv
// ----------------------------------------------------------------------------
// sacm_checker
//
// Port-level assertions for the cache hit model, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sacm_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_hit,
   input logic rsp_filled
);

   // a fill only follows a miss
   `SACM_ASSERT(a_fill_not_hit, rsp_valid |-> !(rsp_filled && rsp_hit), "fill reported on a hit")

   // one request at a time
   `SACM_ASSERT(a_one_in_flight, (req_valid && !req_stall) |=> req_stall, "back-to-back accept")

   // clearing pass and empty output after reset
   `SACM_ASSERT_RST(a_reset_stall, reset |=> req_stall, "request taken during clearing pass")
   `SACM_ASSERT_RST(a_reset_empty, reset |=> !rsp_valid, "response valid after reset")

   // a stalled response stays offered
   `SACM_ASSERT(a_rsp_hold, (rsp_valid && rsp_stall) |=> rsp_valid, "stalled response dropped")

endmodule

bind set_assoc_cache_hit_model sacm_checker u_checker (.*);
